/* rtl/csvp_pkg.sv */
// ----------------------------------------------------------------------------
// csvp_pkg: shared types and constants for the CSV stream parser
// Holds the byte classes, result kinds, status codes, the register indexes
// and the records that pass between the front queue, the parser core and
// the result queue.
// ----------------------------------------------------------------------------
package csvp_pkg;

  // Default build values
  localparam int MAX_COLUMNS_DEF    = 256;
  localparam int ROW_COUNT_BITS_DEF = 16;

  // Queue depths (powers of two)
  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;

  // Field widths fixed by the interface
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 16;
  localparam int LIMIT_W  = 16;

  // Special source bytes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Input command
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic {
    REG_ROW_LIMIT_ENABLE = 1'b0,
    REG_ROW_LIMIT        = 1'b1
  } reg_idx_t;

  // Byte class worked out on entry
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_QUOTE,
    CLS_COMMA,
    CLS_LF,
    CLS_CR
  } cls_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_ROW_END   = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_DONE      = 3'd4
  } kind_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_QUOTE_MID   = 3'd1,
    ST_TEXT_AFTER  = 3'd2,
    ST_OPEN_QUOTE  = 3'd3,
    ST_ROW_LIMIT   = 3'd4,
    ST_RAGGED      = 3'd5,
    ST_NO_ROWS     = 3'd6,
    ST_TOO_MANY    = 3'd7
  } status_t;

  // Classified input item
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data;
    cls_t        cls;
  } item_t;

  // One result transaction
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  field_byte;
    logic [7:0]  column;
    logic [15:0] row;
    status_t     status;
    logic        last;
  } res_t;

  // Write request from the core into the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_wr_t;

  // Sort a source byte into its class
  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c = CLS_OTHER;
    unique case (b)
      CH_QUOTE: c = CLS_QUOTE;
      CH_COMMA: c = CLS_COMMA;
      CH_LF:    c = CLS_LF;
      CH_CR:    c = CLS_CR;
      default:  c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

/* rtl/csvp_front.sv */
// ----------------------------------------------------------------------------
// csvp_front: input queue with byte classification
// Accepts push transactions, tags each source byte with its class and holds
// the items in a short queue for the parser core.
// ----------------------------------------------------------------------------
module csvp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            cmd,
  input  logic [7:0]      source_byte,
  output logic            item_valid,
  output csvp_pkg::item_t item,
  input  logic            item_take
);

  localparam int AW = $clog2(csvp_pkg::IN_DEPTH);
  localparam int CW = $clog2(csvp_pkg::IN_DEPTH + 1);

  csvp_pkg::item_t mem [csvp_pkg::IN_DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            wr_en;
  logic            rd_en;
  csvp_pkg::item_t wr_item;

  assign full       = (count == CW'(csvp_pkg::IN_DEPTH));
  assign item_valid = (count != '0);
  assign item       = mem[rptr];
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;

  // classify on entry
  always_comb begin
    wr_item.cmd  = csvp_pkg::cmd_t'(cmd);
    wr_item.data = source_byte;
    wr_item.cls  = csvp_pkg::classify(source_byte);
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + AW'(1);
      if (rd_en) rptr <= rptr + AW'(1);
      priority case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/csvp_core.sv */
// ----------------------------------------------------------------------------
// csvp_core: CSV parse state machine
// Takes one classified item per cycle whenever the result queue has room
// for two results, updates the quote, row and column state and hands up to
// two results to the result queue.
// ----------------------------------------------------------------------------
module csvp_core #(
  parameter int MAX_COLUMNS    = csvp_pkg::MAX_COLUMNS_DEF,
  parameter int ROW_COUNT_BITS = csvp_pkg::ROW_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  csvp_pkg::item_t                item,
  output logic                           item_take,
  input  logic [$clog2(csvp_pkg::OUT_DEPTH+1)-1:0] out_level,
  output csvp_pkg::res_wr_t              wr,
  input  logic                           row_limit_enable,
  input  logic [csvp_pkg::LIMIT_W-1:0]   row_limit
);

  localparam int CIW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int FW  = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = ROW_COUNT_BITS;
  localparam int LW  = (RW > csvp_pkg::LIMIT_W) ? RW : csvp_pkg::LIMIT_W;
  localparam int LVW = $clog2(csvp_pkg::OUT_DEPTH + 1);

  // quote phases
  typedef enum logic [1:0] {
    QP_OUT     = 2'd0,
    QP_IN      = 2'd1,
    QP_PENDING = 2'd2
  } qphase_t;

  // parse state
  qphase_t           quote_phase, quote_phase_next;
  logic              after_cr, after_cr_next;
  logic              field_has_text, field_has_text_next;
  logic              quote_closed, quote_closed_next;
  logic              row_just_ended, row_just_ended_next;
  logic              any_byte_seen, any_byte_seen_next;
  logic [CIW-1:0]    col_pos, col_pos_next;
  logic [RW-1:0]     row_count, row_count_next;
  logic [FW-1:0]     first_row_width, first_row_width_next;
  logic              ragged_seen, ragged_seen_next;
  csvp_pkg::status_t error_code, error_code_next;

  // room for the worst case of two results
  assign item_take = item_valid && (out_level <= LVW'(csvp_pkg::OUT_DEPTH - 2));

  // next state and results
  always_comb begin
    csvp_pkg::res_t res [2];
    logic [1:0]     n;
    logic           skip;
    logic           closed;
    logic           fin;
    logic           over;
    logic [FW-1:0]  width;
    logic [RW-1:0]  row_new;
    logic           ragged_new;

    res[0] = '0;
    res[1] = '0;
    n      = '0;
    skip   = 1'b0;
    closed = 1'b0;
    fin    = 1'b0;
    over   = 1'b0;
    width  = FW'(col_pos) + FW'(1);
    row_new    = (row_count == '1) ? row_count : row_count + RW'(1);
    ragged_new = ragged_seen ||
                 ((first_row_width != '0) && (first_row_width != width));

    quote_phase_next     = quote_phase;
    after_cr_next        = after_cr;
    field_has_text_next  = field_has_text;
    quote_closed_next    = quote_closed;
    row_just_ended_next  = row_just_ended;
    any_byte_seen_next   = any_byte_seen;
    col_pos_next         = col_pos;
    row_count_next       = row_count;
    first_row_width_next = first_row_width;
    ragged_seen_next     = ragged_seen;
    error_code_next      = error_code;

    if (item.cmd == csvp_pkg::CMD_BYTE) begin
      // source byte; ignored once an error is latched
      if (error_code == csvp_pkg::ST_OK) begin
        any_byte_seen_next = 1'b1;
        if (after_cr) begin
          after_cr_next = 1'b0;
          skip = (item.cls == csvp_pkg::CLS_LF);
        end
        if (!skip) begin
          if (quote_phase == QP_IN) begin
            if (item.cls == csvp_pkg::CLS_QUOTE) begin
              quote_phase_next = QP_PENDING;
            end else begin
              res[0] = '{csvp_pkg::KIND_BYTE, item.data, 8'(col_pos),
                         16'(row_count), csvp_pkg::ST_OK, 1'b0};
              n = 2'd1;
            end
          end else if (quote_phase == QP_PENDING && item.cls == csvp_pkg::CLS_QUOTE) begin
            // doubled quote inside quotes
            quote_phase_next = QP_IN;
            res[0] = '{csvp_pkg::KIND_BYTE, csvp_pkg::CH_QUOTE, 8'(col_pos),
                       16'(row_count), csvp_pkg::ST_OK, 1'b0};
            n = 2'd1;
          end else begin
            // outside quotes, possibly just closing a pending quote
            closed = quote_closed || (quote_phase == QP_PENDING);
            if (quote_phase == QP_PENDING) begin
              quote_phase_next  = QP_OUT;
              quote_closed_next = 1'b1;
            end
            unique case (item.cls)
              csvp_pkg::CLS_QUOTE: begin
                if (field_has_text || closed) begin
                  error_code_next = csvp_pkg::ST_QUOTE_MID;
                  res[0] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'(col_pos),
                             16'(row_count), csvp_pkg::ST_QUOTE_MID, 1'b0};
                  n = 2'd1;
                end else begin
                  quote_phase_next    = QP_IN;
                  row_just_ended_next = 1'b0;
                end
              end
              csvp_pkg::CLS_COMMA: begin
                if (col_pos == CIW'(MAX_COLUMNS - 1)) begin
                  error_code_next = csvp_pkg::ST_TOO_MANY;
                  res[0] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'(col_pos),
                             16'(row_count), csvp_pkg::ST_TOO_MANY, 1'b0};
                  n = 2'd1;
                end else begin
                  res[0] = '{csvp_pkg::KIND_FIELD_END, 8'h00, 8'(col_pos),
                             16'(row_count), csvp_pkg::ST_OK, 1'b0};
                  n = 2'd1;
                  col_pos_next        = col_pos + CIW'(1);
                  field_has_text_next = 1'b0;
                  quote_closed_next   = 1'b0;
                  row_just_ended_next = 1'b0;
                end
              end
              csvp_pkg::CLS_LF, csvp_pkg::CLS_CR: begin
                // row end
                res[0] = '{csvp_pkg::KIND_ROW_END, 8'h00, 8'(col_pos),
                           16'(row_count), csvp_pkg::ST_OK, 1'b0};
                n = 2'd1;
                if (first_row_width == '0) first_row_width_next = width;
                ragged_seen_next    = ragged_new;
                row_count_next      = row_new;
                col_pos_next        = '0;
                field_has_text_next = 1'b0;
                quote_closed_next   = 1'b0;
                row_just_ended_next = 1'b1;
                over = row_limit_enable && (LW'(row_new) > LW'(row_limit));
                if (over) begin
                  error_code_next = csvp_pkg::ST_ROW_LIMIT;
                  res[1] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'h00,
                             16'(row_new), csvp_pkg::ST_ROW_LIMIT, 1'b0};
                  n = 2'd2;
                end else if (item.cls == csvp_pkg::CLS_CR) begin
                  after_cr_next = 1'b1;
                end
              end
              default: begin
                if (closed) begin
                  error_code_next = csvp_pkg::ST_TEXT_AFTER;
                  res[0] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'(col_pos),
                             16'(row_count), csvp_pkg::ST_TEXT_AFTER, 1'b0};
                  n = 2'd1;
                end else begin
                  res[0] = '{csvp_pkg::KIND_BYTE, item.data, 8'(col_pos),
                             16'(row_count), csvp_pkg::ST_OK, 1'b0};
                  n = 2'd1;
                  field_has_text_next = 1'b1;
                  row_just_ended_next = 1'b0;
                end
              end
            endcase
          end
        end
      end
    end else begin
      // end of input: final result, then back to the reset state
      if (error_code != csvp_pkg::ST_OK) begin
        res[0] = '{csvp_pkg::KIND_DONE, 8'h00, 8'h00, 16'(row_count), error_code, 1'b1};
        n = 2'd1;
      end else if (quote_phase == QP_IN) begin
        res[0] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'(col_pos), 16'(row_count),
                   csvp_pkg::ST_OPEN_QUOTE, 1'b1};
        n = 2'd1;
      end else begin
        fin = any_byte_seen && !row_just_ended;
        if (fin) begin
          res[0] = '{csvp_pkg::KIND_ROW_END, 8'h00, 8'(col_pos),
                     16'(row_count), csvp_pkg::ST_OK, 1'b0};
          over = row_limit_enable && (LW'(row_new) > LW'(row_limit));
        end else begin
          row_new    = row_count;
          ragged_new = ragged_seen;
        end
        if (over) begin
          res[1] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'h00, 16'(row_new),
                     csvp_pkg::ST_ROW_LIMIT, 1'b1};
        end else if (row_new == '0) begin
          res[1] = '{csvp_pkg::KIND_ERROR, 8'h00,
                     fin ? 8'h00 : 8'(col_pos), 16'(row_new),
                     csvp_pkg::ST_NO_ROWS, 1'b1};
        end else if (ragged_new) begin
          res[1] = '{csvp_pkg::KIND_ERROR, 8'h00, 8'h00, 16'(row_new),
                     csvp_pkg::ST_RAGGED, 1'b1};
        end else begin
          res[1] = '{csvp_pkg::KIND_DONE, 8'h00, 8'h00, 16'(row_new),
                     csvp_pkg::ST_OK, 1'b1};
        end
        // move the final result down when no row end went first
        if (fin) begin
          n = 2'd2;
        end else begin
          res[0] = res[1];
          res[1] = '0;
          n = 2'd1;
        end
      end
      quote_phase_next     = QP_OUT;
      after_cr_next        = 1'b0;
      field_has_text_next  = 1'b0;
      quote_closed_next    = 1'b0;
      row_just_ended_next  = 1'b0;
      any_byte_seen_next   = 1'b0;
      col_pos_next         = '0;
      row_count_next       = '0;
      first_row_width_next = '0;
      ragged_seen_next     = 1'b0;
      error_code_next      = csvp_pkg::ST_OK;
    end

    wr.cnt = item_take ? n : 2'd0;
    wr.r0  = res[0];
    wr.r1  = res[1];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_phase     <= QP_OUT;
      after_cr        <= 1'b0;
      field_has_text  <= 1'b0;
      quote_closed    <= 1'b0;
      row_just_ended  <= 1'b0;
      any_byte_seen   <= 1'b0;
      col_pos         <= '0;
      row_count       <= '0;
      first_row_width <= '0;
      ragged_seen     <= 1'b0;
      error_code      <= csvp_pkg::ST_OK;
    end else if (item_take) begin
      quote_phase     <= quote_phase_next;
      after_cr        <= after_cr_next;
      field_has_text  <= field_has_text_next;
      quote_closed    <= quote_closed_next;
      row_just_ended  <= row_just_ended_next;
      any_byte_seen   <= any_byte_seen_next;
      col_pos         <= col_pos_next;
      row_count       <= row_count_next;
      first_row_width <= first_row_width_next;
      ragged_seen     <= ragged_seen_next;
      error_code      <= error_code_next;
    end
  end

endmodule

/* rtl/csvp_out_fifo.sv */
// ----------------------------------------------------------------------------
// csvp_out_fifo: result queue
// Takes up to two results per cycle from the parser core and presents the
// oldest one on the pop side.
// ----------------------------------------------------------------------------
module csvp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  csvp_pkg::res_wr_t wr,
  output logic [$clog2(csvp_pkg::OUT_DEPTH+1)-1:0] level,
  output logic              empty,
  input  logic              pop,
  output csvp_pkg::res_t    head
);

  localparam int AW = $clog2(csvp_pkg::OUT_DEPTH);
  localparam int CW = $clog2(csvp_pkg::OUT_DEPTH + 1);

  csvp_pkg::res_t mem [csvp_pkg::OUT_DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           rd_en;

  assign empty = (count == '0);
  assign level = count;
  assign head  = mem[rptr];
  assign rd_en = pop && !empty;

  // storage: two write slots
  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem[wptr] <= wr.r0;
    end
    if (wr.cnt == 2'd2) begin
      mem[wptr + AW'(1)] <= wr.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(wr.cnt);
      if (rd_en) rptr <= rptr + AW'(1);
      count <= count + CW'(wr.cnt) - CW'(rd_en);
    end
  end

endmodule

/* rtl/csv_stream_parser.sv */
// ----------------------------------------------------------------------------
// csv_stream_parser: streaming CSV reader
// Decodes CSV source bytes into field bytes, field ends and row ends with
// column and row numbers, and reports syntax and table errors.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  input    | in        | push / full        | cmd, source_byte
//  result   | out       | empty / pop        | kind, field_byte, column, row,
//           |           |                    | status, last
//  config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle is taken while the result queue has room; the parser
// core needs room for two results in the four-entry result queue before it
// updates its state. The first result of an item is registered in the input
// queue and then in the result queue before it reaches the result ports.
// Synchronous reset empties both queues, clears the parse state and sets the
// registers to row limit off, limit 65535. A stalled result side fills the
// result queue, then the input queue, and then raises full.
// ----------------------------------------------------------------------------
module csv_stream_parser #(
  parameter int MAX_COLUMNS    = csvp_pkg::MAX_COLUMNS_DEF,
  parameter int ROW_COUNT_BITS = csvp_pkg::ROW_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  source_byte,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [7:0]  field_byte,
  output logic [7:0]  column,
  output logic [15:0] row,
  output logic [2:0]  status,
  output logic        last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LVW = $clog2(csvp_pkg::OUT_DEPTH + 1);

  logic                         item_valid;
  csvp_pkg::item_t              item;
  logic                         item_take;
  csvp_pkg::res_wr_t            wr;
  logic [LVW-1:0]               out_level;
  csvp_pkg::res_t               head;
  logic                         row_limit_enable;
  logic [csvp_pkg::LIMIT_W-1:0] row_limit;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit_enable <= 1'b0;
      row_limit        <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (csvp_pkg::reg_idx_t'(cfg_index))
        csvp_pkg::REG_ROW_LIMIT_ENABLE: row_limit_enable <= cfg_data[0];
        csvp_pkg::REG_ROW_LIMIT:        row_limit        <= cfg_data;
        default:                        row_limit        <= row_limit;
      endcase
    end
  end

  csvp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .source_byte (source_byte),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  csvp_core #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item             (item),
    .item_take        (item_take),
    .out_level        (out_level),
    .wr               (wr),
    .row_limit_enable (row_limit_enable),
    .row_limit        (row_limit)
  );

  csvp_out_fifo u_out (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .level (out_level),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  // result fields
  assign kind       = head.kind;
  assign field_byte = head.field_byte;
  assign column     = head.column;
  assign row        = head.row;
  assign status     = head.status;
  assign last       = head.last;

  // result queue never takes more than it has room for
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr.cnt != 2'd0) |-> (LVW'(out_level) + LVW'(wr.cnt) <= LVW'(csvp_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  // the closing result of a parse is a done or an error
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (kind == csvp_pkg::KIND_DONE || kind == csvp_pkg::KIND_ERROR))
    else $error("last set on a non-final result");

  // only field bytes carry data
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != csvp_pkg::KIND_BYTE) |-> (field_byte == 8'h00))
    else $error("field_byte set on a marker result");

  // status is only reported by error and done results
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != csvp_pkg::KIND_DONE && kind != csvp_pkg::KIND_ERROR)
      |-> (status == csvp_pkg::ST_OK))
    else $error("status set on a data result");

endmodule

/* dv/tb_csv_stream_parser.sv */
// ----------------------------------------------------------------------------
// tb_csv_stream_parser: self-checking bench for the CSV stream parser
// Pushes directed and random CSV source through the input queue, predicts
// each result with a behavioural parser of its own or takes it from a typed
// row of the directed table, and compares each popped result field by field.
// Both queue sides idle in random bursts. The run goes through several row
// limit settings and ends with a phase in which neither side idles.
// ----------------------------------------------------------------------------
module tb_csv_stream_parser;

  localparam int ROW_MAX     = (1 << csvp_pkg::ROW_COUNT_BITS_DEF) - 1;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 320;
  localparam int N_PHASES    = 5;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {Q_OUT, Q_IN, Q_PEND} quote_st_t;
  typedef enum logic {PLAN_ITEM, PLAN_CFG} plan_op_t;

  // One row of the directed table; n_typed < 0 means use the parser model
  typedef struct {
    plan_op_t         op;
    csvp_pkg::cmd_t   c;
    logic [7:0]       b;
    int               n_typed;
    csvp_pkg::res_t   t0;
    csvp_pkg::res_t   t1;
    logic             cfg_en;
    logic [15:0]      cfg_lim;
  } plan_row_t;

  typedef struct {
    csvp_pkg::cmd_t c;
    logic [7:0]     b;
  } src_item_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic        full;
  logic        cmd         = 1'b0;
  logic [7:0]  source_byte = 8'h00;
  logic        empty;
  logic        pop         = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  field_byte;
  logic [7:0]  column;
  logic [15:0] row;
  logic [2:0]  status;
  logic        last;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic        cfg_index   = 1'b0;
  logic [15:0] cfg_data    = 16'h0000;

  // Typed expectations travel alongside the pushed item
  int             typed_n  = -1;
  csvp_pkg::res_t typed_r0 = '0;
  csvp_pkg::res_t typed_r1 = '0;

  logic        idle_on  = 1'b1;
  int          stall_left;

  // Parser model state and register copies
  quote_st_t         q_state;
  logic              cr_pending, fld_text, fld_closed, row_fresh, seen_bytes, ragged;
  int                col_idx, row_cnt, width_first;
  csvp_pkg::status_t err;
  logic              lim_en;
  logic [15:0]       lim_val;

  csvp_pkg::res_t step_q[$];
  csvp_pkg::res_t parse_results_q[$];
  plan_row_t      dir_plan[$];
  src_item_t      src_q[$];
  int             n_mismatch = 0;

  csv_stream_parser i_dut (
    .clk, .rst, .push, .full, .cmd, .source_byte, .empty, .pop, .kind,
    .field_byte, .column, .row, .status, .last, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic void clear_parse_state();
    q_state     = Q_OUT;
    cr_pending  = 1'b0;
    fld_text    = 1'b0;
    fld_closed  = 1'b0;
    row_fresh   = 1'b0;
    seen_bytes  = 1'b0;
    ragged      = 1'b0;
    col_idx     = 0;
    row_cnt     = 0;
    width_first = 0;
    err         = csvp_pkg::ST_OK;
  endfunction

  function automatic void emit(csvp_pkg::kind_t k, logic [7:0] b,
                               csvp_pkg::status_t st, logic lst);
    csvp_pkg::res_t r;
    r.kind       = k;
    r.field_byte = b;
    r.column     = col_idx[7:0];
    r.row        = row_cnt[15:0];
    r.status     = st;
    r.last       = lst;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic void flag_error(csvp_pkg::status_t code, logic lst);
    err = code;
    emit(csvp_pkg::KIND_ERROR, 8'h00, code, lst);
  endfunction

  // Row end marker plus bookkeeping; returns 1 when the limit is exceeded
  function automatic logic close_row();
    int w;
    w = col_idx + 1;
    emit(csvp_pkg::KIND_ROW_END, 8'h00, csvp_pkg::ST_OK, 1'b0);
    if (width_first == 0) width_first = w;
    else if (width_first != w) ragged = 1'b1;
    if (row_cnt < ROW_MAX) row_cnt++;
    col_idx    = 0;
    fld_text   = 1'b0;
    fld_closed = 1'b0;
    row_fresh  = 1'b1;
    return lim_en && (row_cnt > int'(lim_val));
  endfunction

  function automatic void unquoted_byte(logic [7:0] c);
    if (c == csvp_pkg::CH_QUOTE) begin
      if (fld_text || fld_closed) begin
        flag_error(csvp_pkg::ST_QUOTE_MID, 1'b0);
      end else begin
        q_state   = Q_IN;
        row_fresh = 1'b0;
      end
    end else if (c == csvp_pkg::CH_COMMA) begin
      if (col_idx + 1 >= csvp_pkg::MAX_COLUMNS_DEF) begin
        flag_error(csvp_pkg::ST_TOO_MANY, 1'b0);
      end else begin
        emit(csvp_pkg::KIND_FIELD_END, 8'h00, csvp_pkg::ST_OK, 1'b0);
        col_idx++;
        fld_text   = 1'b0;
        fld_closed = 1'b0;
        row_fresh  = 1'b0;
      end
    end else if (c == csvp_pkg::CH_LF || c == csvp_pkg::CH_CR) begin
      if (close_row()) flag_error(csvp_pkg::ST_ROW_LIMIT, 1'b0);
      else if (c == csvp_pkg::CH_CR) cr_pending = 1'b1;
    end else if (fld_closed) begin
      flag_error(csvp_pkg::ST_TEXT_AFTER, 1'b0);
    end else begin
      emit(csvp_pkg::KIND_BYTE, c, csvp_pkg::ST_OK, 1'b0);
      fld_text  = 1'b1;
      row_fresh = 1'b0;
    end
  endfunction

  // Works out the results of one accepted item into step_q
  function automatic void predict_item(csvp_pkg::cmd_t c, logic [7:0] b);
    logic over;
    step_q.delete();
    if (c == csvp_pkg::CMD_BYTE) begin
      if (err != csvp_pkg::ST_OK) return;
      seen_bytes = 1'b1;
      if (cr_pending) begin
        cr_pending = 1'b0;
        if (b == csvp_pkg::CH_LF) return;
      end
      if (q_state == Q_IN) begin
        if (b == csvp_pkg::CH_QUOTE) q_state = Q_PEND;
        else emit(csvp_pkg::KIND_BYTE, b, csvp_pkg::ST_OK, 1'b0);
        return;
      end
      if (q_state == Q_PEND) begin
        if (b == csvp_pkg::CH_QUOTE) begin
          q_state = Q_IN;
          emit(csvp_pkg::KIND_BYTE, csvp_pkg::CH_QUOTE, csvp_pkg::ST_OK, 1'b0);
          return;
        end
        q_state    = Q_OUT;
        fld_closed = 1'b1;
      end
      unquoted_byte(b);
    end else begin
      // end of input: close the last row, then check the table
      if (err != csvp_pkg::ST_OK) begin
        col_idx = 0;
        emit(csvp_pkg::KIND_DONE, 8'h00, err, 1'b1);
      end else if (q_state == Q_IN) begin
        flag_error(csvp_pkg::ST_OPEN_QUOTE, 1'b1);
      end else begin
        over = 1'b0;
        if (seen_bytes && !row_fresh) over = close_row();
        if (over) flag_error(csvp_pkg::ST_ROW_LIMIT, 1'b1);
        else if (row_cnt == 0) flag_error(csvp_pkg::ST_NO_ROWS, 1'b1);
        else if (ragged) flag_error(csvp_pkg::ST_RAGGED, 1'b1);
        else begin
          col_idx = 0;
          emit(csvp_pkg::KIND_DONE, 8'h00, csvp_pkg::ST_OK, 1'b1);
        end
      end
      clear_parse_state();
    end
  endfunction

  function automatic string res_str(csvp_pkg::res_t r);
    return $sformatf("kind %0d byte %02h col %0d row %0d status %0d last %0b",
                     r.kind, r.field_byte, r.column, r.row, r.status, r.last);
  endfunction

  // ------------------------------------------------------------ checking
  always @(posedge clk) begin
    csvp_pkg::res_t got, want;
    if (!rst) begin
      // result transaction
      if (pop && !empty) begin
        got = '{csvp_pkg::kind_t'(kind), field_byte, column, row,
                csvp_pkg::status_t'(status), last};
        if (parse_results_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("unexpected result: %s", res_str(got));
        end else begin
          want = parse_results_q.pop_front();
          if (got.kind !== want.kind || got.field_byte !== want.field_byte ||
              got.column !== want.column || got.row !== want.row ||
              got.status !== want.status || got.last !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
              $display("mismatch: expected %s, got %s", res_str(want), res_str(got));
          end
        end
      end
      // input transaction
      if (push && !full) begin
        predict_item(csvp_pkg::cmd_t'(cmd), source_byte);
        if (typed_n < 0) begin
          foreach (step_q[i]) parse_results_q.insert(parse_results_q.size(), step_q[i]);
        end else begin
          if (typed_n > 0) parse_results_q.insert(parse_results_q.size(), typed_r0);
          if (typed_n > 1) parse_results_q.insert(parse_results_q.size(), typed_r1);
        end
      end
    end
  end

  // Result side: pop with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // ------------------------------------------------------------- driving
  task automatic send_item(csvp_pkg::cmd_t c, logic [7:0] b, int n = -1,
                           csvp_pkg::res_t t0 = '0, csvp_pkg::res_t t1 = '0);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push        <= 1'b1;
    cmd         <= c;
    source_byte <= b;
    typed_n     <= n;
    typed_r0    <= t0;
    typed_r1    <= t1;
    do @(posedge clk); while (full);
  endtask

  // Wait for every expected result, then let any result-free items settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (parse_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic en, logic [15:0] lim);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= csvp_pkg::REG_ROW_LIMIT_ENABLE;
    cfg_data  <= {15'($urandom), en};
    do @(posedge clk); while (!cfg_ready);
    lim_en = en;
    cfg_index <= csvp_pkg::REG_ROW_LIMIT;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    lim_val = lim;
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------ stimulus
  function automatic void tab_item(csvp_pkg::cmd_t c, logic [7:0] b, int n = -1,
                                   csvp_pkg::res_t t0 = '0, csvp_pkg::res_t t1 = '0);
    plan_row_t pr;
    pr = '{PLAN_ITEM, c, b, n, t0, t1, 1'b0, 16'h0000};
    dir_plan.insert(dir_plan.size(), pr);
  endfunction

  function automatic void tab_cfg(logic en, logic [15:0] lim);
    plan_row_t pr;
    pr = '{PLAN_CFG, csvp_pkg::CMD_BYTE, 8'h00, -1, '0, '0, en, lim};
    dir_plan.insert(dir_plan.size(), pr);
  endfunction

  function automatic void add_src(csvp_pkg::cmd_t c, logic [7:0] b);
    src_item_t si;
    si.c = c;
    si.b = b;
    src_q.insert(src_q.size(), si);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom);
    while (v == csvp_pkg::CH_QUOTE || v == csvp_pkg::CH_COMMA ||
           v == csvp_pkg::CH_LF || v == csvp_pkg::CH_CR);
    return v;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return csvp_pkg::CH_QUOTE;
      1:       return csvp_pkg::CH_COMMA;
      2:       return csvp_pkg::CH_LF;
      3:       return csvp_pkg::CH_CR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_field(logic quoted);
    int len;
    len = $urandom_range(0, 4);
    if (!quoted) begin
      repeat (len) add_src(csvp_pkg::CMD_BYTE, plain_byte());
    end else begin
      add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
      repeat (len) begin
        case ($urandom_range(0, 7))
          0: add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_COMMA);
          1: add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_CR);
          2: add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF);
          3: begin
            // doubled quote inside a quoted field
            add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
            add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
          end
          default: add_src(csvp_pkg::CMD_BYTE, plain_byte());
        endcase
      end
      add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    end
  endfunction

  function automatic void add_row_end();
    case ($urandom_range(0, 2))
      0: add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF);
      1: add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_CR);
      default: begin
        add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_CR);
        add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF);
      end
    endcase
  endfunction

  // Well-formed table, now and then with a row of another width
  function automatic void add_table();
    int nrows, ncols, w;
    nrows = $urandom_range(1, 5);
    ncols = $urandom_range(1, 4);
    for (int r = 0; r < nrows; r++) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : ncols;
      for (int f = 0; f < w; f++) begin
        if (f != 0) add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_COMMA);
        add_field($urandom_range(0, 2) == 0);
      end
      if (r < nrows - 1 || $urandom_range(0, 2) != 0) add_row_end();
    end
  endfunction

  // One parse into src_q; returns how many items it holds
  function automatic int build_parse();
    int sel;
    src_item_t si;
    src_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      // wide row up to and past the column limit
      repeat ($urandom_range(csvp_pkg::MAX_COLUMNS_DEF - 2, csvp_pkg::MAX_COLUMNS_DEF))
        add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_COMMA);
      add_src(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF);
    end else if (sel < 8) begin
      repeat ($urandom_range(0, 2)) add_row_end();
    end else if (sel < 20) begin
      repeat ($urandom_range(1, 16)) add_src(csvp_pkg::CMD_BYTE, noise_byte());
    end else begin
      add_table();
      if (sel < 35) begin
        si.c = csvp_pkg::CMD_BYTE;
        si.b = noise_byte();
        src_q.insert($urandom_range(0, src_q.size()), si);
      end
    end
    add_src(csvp_pkg::CMD_END, 8'($urandom));
    return src_q.size();
  endfunction

  // ---------------------------------------------------------------- main
  initial begin
    int cnt;
    lim_en  = 1'b0;
    lim_val = 16'hFFFF;
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    tab_item(csvp_pkg::CMD_END, 8'h00, 1, '{csvp_pkg::KIND_ERROR, 8'h00, 8'd0, 16'd0,
                                            csvp_pkg::ST_NO_ROWS, 1'b1});
    tab_item(csvp_pkg::CMD_BYTE, 8'h00, 1, '{csvp_pkg::KIND_BYTE, 8'h00, 8'd0, 16'd0,
                                             csvp_pkg::ST_OK, 1'b0});
    tab_item(csvp_pkg::CMD_BYTE, 8'hFF, 1, '{csvp_pkg::KIND_BYTE, 8'hFF, 8'd0, 16'd0,
                                             csvp_pkg::ST_OK, 1'b0});
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_COMMA, 1,
             '{csvp_pkg::KIND_FIELD_END, 8'h00, 8'd0, 16'd0, csvp_pkg::ST_OK, 1'b0});
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE, 0);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_COMMA);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_CR);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF, 0);
    tab_item(csvp_pkg::CMD_BYTE, 8'h61);
    tab_item(csvp_pkg::CMD_END, 8'hA5);
    // text after a closing quote, then ignored bytes
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    tab_item(csvp_pkg::CMD_BYTE, 8'h78);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    tab_item(csvp_pkg::CMD_BYTE, 8'h79, 1, '{csvp_pkg::KIND_ERROR, 8'h00, 8'd0, 16'd0,
                                             csvp_pkg::ST_TEXT_AFTER, 1'b0});
    tab_item(csvp_pkg::CMD_BYTE, 8'h7A, 0);
    tab_item(csvp_pkg::CMD_END, 8'h00, 1, '{csvp_pkg::KIND_DONE, 8'h00, 8'd0, 16'd0,
                                            csvp_pkg::ST_TEXT_AFTER, 1'b1});
    // quote in the middle of a field
    tab_item(csvp_pkg::CMD_BYTE, 8'h71);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE, 1,
             '{csvp_pkg::KIND_ERROR, 8'h00, 8'd0, 16'd0, csvp_pkg::ST_QUOTE_MID, 1'b0});
    tab_item(csvp_pkg::CMD_END, 8'h00);
    // input ends inside quotes
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_QUOTE);
    tab_item(csvp_pkg::CMD_END, 8'h00, 1, '{csvp_pkg::KIND_ERROR, 8'h00, 8'd0, 16'd0,
                                            csvp_pkg::ST_OPEN_QUOTE, 1'b1});
    // row limit of one
    tab_cfg(1'b1, 16'd1);
    tab_item(csvp_pkg::CMD_BYTE, 8'h61);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF);
    tab_item(csvp_pkg::CMD_BYTE, 8'h62);
    tab_item(csvp_pkg::CMD_BYTE, csvp_pkg::CH_LF);
    tab_item(csvp_pkg::CMD_END, 8'h00);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].op == PLAN_CFG) write_regs(dir_plan[i].cfg_en, dir_plan[i].cfg_lim);
      else send_item(dir_plan[i].c, dir_plan[i].b, dir_plan[i].n_typed,
                     dir_plan[i].t0, dir_plan[i].t1);
    end

    // random phases over several register settings; the last one never idles
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) idle_on <= 1'b0;
      case (p)
        0:       write_regs(1'b0, 16'hFFFF);
        1:       write_regs(1'b1, 16'd0);
        2:       write_regs(1'b1, 16'($urandom_range(1, 3)));
        3:       write_regs(1'b0, 16'd0);
        default: write_regs(1'b1, 16'($urandom_range(2, 6)));
      endcase
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        cnt += build_parse();
        if (p != N_PHASES - 1) idle_on <= ($urandom_range(0, 3) != 0);
        foreach (src_q[i]) send_item(src_q[i].c, src_q[i].b);
      end
    end
    drain();

    if (n_mismatch == 0 && parse_results_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
